// ===== rtl/aopf_pkg.sv =====
package aopf_pkg;

  localparam int Channels   = 32;
  localparam int MaxResults = 32;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  localparam logic [31:0] UsPerMs = 32'd1000;

  localparam logic [15:0] RstTimeoutMs = 16'd500;
  localparam logic [5:0]  RstOutputs   = 6'd32;
  localparam logic [15:0] RstFloor     = 16'd500;
  localparam logic [15:0] RstCeiling   = 16'd2500;
  localparam logic [15:0] RstThreshold = 16'd1500;

  typedef enum logic [1:0] {
    OP_COMMAND = 2'd0,
    OP_TICK    = 2'd1,
    OP_SETUP   = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_DISABLED = 2'd0,
    KIND_PWM      = 2'd1,
    KIND_ONOFF    = 2'd2,
    KIND_PULSE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_TIMEOUT   = 3'd0,
    REG_OUTPUTS   = 3'd1,
    REG_FLOOR     = 3'd2,
    REG_CEILING   = 3'd3,
    REG_THRESHOLD = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    opcode_e            op;
    logic [31:0]        now_us;
    logic [7:0]         chan_id;
    logic signed [15:0] cmd_value;
    logic               command_is_pwm;
    kind_e              setup_kind;
    logic [15:0]        setup_on_width;
    logic [15:0]        setup_off_width;
    logic [15:0]        setup_safe_width;
    logic               setup_safe_on;
    logic [15:0]        setup_pulse_ms;
    logic               setup_restart;
  } item_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [5:0]  outputs;
    logic [15:0] pwm_floor;
    logic [15:0] pwm_ceiling;
    logic [15:0] on_threshold;
  } cfg_t;

  typedef struct packed {
    logic [15:0] on_w;
    logic [15:0] off_w;
    logic [15:0] safe_w;
    kind_e       kind;
    logic        safe_on;
    logic        restart;
    logic [15:0] pulse_ms;
    logic        in_on;
    logic        running;
    logic        wait_off;
    logic [31:0] start;
  } row_t;

  typedef struct packed {
    logic [4:0]  ch;
    logic [15:0] width;
  } res_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

// ===== rtl/aopf_front.sv =====
module aopf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [127:0]         s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  output aopf_pkg::qhead_t     head_o,
  input  logic                 pop_i
);

  aopf_pkg::item_t           mem_q [aopf_pkg::QueueDepth];
  logic [aopf_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [aopf_pkg::QPtrW:0]   cnt_q;
  aopf_pkg::item_t           in_item;
  logic                      push, pop;

  always_comb begin
    in_item.op               = aopf_pkg::opcode_e'(s_axis_tuser);
    in_item.now_us           = s_axis_tdata[31:0];
    in_item.chan_id          = s_axis_tdata[39:32];
    in_item.cmd_value        = s_axis_tdata[55:40];
    in_item.command_is_pwm   = s_axis_tdata[56];
    in_item.setup_kind       = aopf_pkg::kind_e'(s_axis_tdata[58:57]);
    in_item.setup_on_width   = s_axis_tdata[74:59];
    in_item.setup_off_width  = s_axis_tdata[90:75];
    in_item.setup_safe_width = s_axis_tdata[106:91];
    in_item.setup_safe_on    = s_axis_tdata[107];
    in_item.setup_pulse_ms   = s_axis_tdata[123:108];
    in_item.setup_restart    = s_axis_tdata[124];
  end

  assign s_axis_tready = (cnt_q != (aopf_pkg::QPtrW+1)'(aopf_pkg::QueueDepth));
  // drop unused opcodes here, they never reach the back end
  assign push = s_axis_tvalid && s_axis_tready && (in_item.op != aopf_pkg::OP_UNUSED);
  assign pop  = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == (aopf_pkg::QPtrW)'(aopf_pkg::QueueDepth - 1)) ? '0
                  : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == (aopf_pkg::QPtrW)'(aopf_pkg::QueueDepth - 1)) ? '0
                  : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/aopf_back.sv =====
module aopf_back #(
  parameter int CHANNELS = aopf_pkg::Channels
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  aopf_pkg::cfg_t   cfg_i,
  input  aopf_pkg::qhead_t head_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output aopf_pkg::res_t   m_res_o,
  output logic             m_last_o,
  output logic             m_fs_o
);

  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNTW   = $clog2(CHANNELS + 1);
  localparam int SvcMax = (CHANNELS < aopf_pkg::MaxResults) ? CHANNELS : aopf_pkg::MaxResults;
  localparam logic [7:0] IdMax = 8'(CHANNELS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CMD_RD, ST_CMD_EX, ST_WALK_RD, ST_WALK_EX, ST_FLUSH
  } state_e;

  aopf_pkg::row_t mem_q [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  aopf_pkg::row_t rd_q;
  logic           rd_vld_q;

  state_e          state_q;
  aopf_pkg::item_t item_q;
  logic [CNTW-1:0] ctr_q, lim_q;
  logic            fs_walk_q;
  logic            have_cmd_q;
  logic [31:0]     last_time_q;
  logic            fs_q;
  logic            pend_vld_q;
  aopf_pkg::res_t  pend_q;
  logic            out_vld_q;
  aopf_pkg::res_t  out_q;
  logic            out_last_q;
  logic            out_fs_q;

  aopf_pkg::item_t hd;
  aopf_pkg::row_t  row, new_row, setup_row;
  logic [5:0]      svc;
  logic [CW-1:0]   cmd_ch, hd_ch, raddr, waddr;
  logic            re, we;
  aopf_pkg::row_t  wdata;
  logic [31:0]     limit, plen, elapsed;
  logic            stale, hd_cmd_ok, hd_setup_ok;
  logic            emit, out_free, can_go, out_load;
  logic [15:0]     emit_w;
  logic signed [16:0] v17, th17, fl17, ce17, w17;
  logic            on;

  function automatic logic [CW-1:0] raddr_hold(state_e st, logic [CW-1:0] c,
                                               logic [CW-1:0] w);
    return (st == ST_CMD_EX) ? c : w;
  endfunction

  assign hd  = head_i.item;
  assign row = rd_vld_q ? rd_q : '0;

  always_comb begin
    svc = (cfg_i.outputs > 6'(SvcMax)) ? 6'(SvcMax) : cfg_i.outputs;
    hd_ch  = CW'(8'(hd.chan_id - 8'd1));
    cmd_ch = CW'(8'(item_q.chan_id - 8'd1));
    hd_cmd_ok = (hd.chan_id != 8'd0) && (hd.chan_id <= {2'b00, svc})
             && hd.command_is_pwm;
    hd_setup_ok = (hd.chan_id != 8'd0) && (hd.chan_id <= IdMax);
    limit     = {16'b0, cfg_i.timeout_ms} * aopf_pkg::UsPerMs;
    stale     = !have_cmd_q || ((hd.now_us - last_time_q) >= limit);
    plen      = {16'b0, row.pulse_ms} * aopf_pkg::UsPerMs;
    elapsed   = item_q.now_us - row.start;
    out_free  = !out_vld_q || m_ready_i;

    setup_row          = '0;
    setup_row.on_w     = hd.setup_on_width;
    setup_row.off_w    = hd.setup_off_width;
    setup_row.safe_w   = hd.setup_safe_width;
    setup_row.kind     = hd.setup_kind;
    setup_row.safe_on  = hd.setup_safe_on;
    setup_row.restart  = hd.setup_restart;
    setup_row.pulse_ms = hd.setup_pulse_ms;

    v17  = {item_q.cmd_value[15], item_q.cmd_value};
    th17 = $signed({1'b0, cfg_i.on_threshold});
    fl17 = $signed({1'b0, cfg_i.pwm_floor});
    ce17 = $signed({1'b0, cfg_i.pwm_ceiling});
    w17  = (v17 < fl17) ? fl17 : v17;
    w17  = (w17 > ce17) ? ce17 : w17;
    on   = (v17 >= th17);

    new_row = row;
    emit    = 1'b0;
    emit_w  = '0;
    if (state_q == ST_CMD_EX) begin
      case (row.kind)
        aopf_pkg::KIND_DISABLED: begin
          new_row.in_on = 1'b0; new_row.running = 1'b0;
          new_row.wait_off = 1'b0; new_row.start = '0;
        end
        aopf_pkg::KIND_PWM: begin
          emit = 1'b1; emit_w = w17[15:0];
        end
        aopf_pkg::KIND_ONOFF: begin
          emit = 1'b1; emit_w = on ? row.on_w : row.off_w;
        end
        default: begin
          new_row.in_on = on;
          if (!on) begin
            new_row.wait_off = 1'b0;
          end else if (row.running) begin
            if (row.restart) new_row.start = item_q.now_us;
          end else if (!row.wait_off && !row.in_on) begin
            new_row.running = 1'b1;
            new_row.start   = item_q.now_us;
            emit = 1'b1; emit_w = row.on_w;
          end
        end
      endcase
    end else if (fs_walk_q) begin
      emit   = (row.kind != aopf_pkg::KIND_DISABLED);
      emit_w = (row.kind == aopf_pkg::KIND_PWM) ? row.safe_w
             : (row.safe_on ? row.on_w : row.off_w);
      new_row.in_on = 1'b0; new_row.running = 1'b0;
      new_row.wait_off = 1'b0; new_row.start = '0;
    end else if ((row.kind == aopf_pkg::KIND_PULSE) && row.running && (elapsed >= plen)) begin
      emit   = 1'b1;
      emit_w = row.off_w;
      new_row.running = 1'b0;
      if (!row.restart && row.in_on) new_row.wait_off = 1'b1;
    end

    can_go = !emit || !pend_vld_q || out_free;
    out_load = (((state_q == ST_CMD_EX) || (state_q == ST_WALK_EX)) && can_go && emit
                && pend_vld_q) || ((state_q == ST_FLUSH) && pend_vld_q && out_free);

    re    = (state_q == ST_CMD_RD) || (state_q == ST_WALK_RD);
    raddr = (state_q == ST_CMD_RD) ? cmd_ch : ctr_q[CW-1:0];
    we    = 1'b0;
    waddr = hd_ch;
    wdata = setup_row;
    case (state_q)
      ST_IDLE: we = head_i.valid && (hd.op == aopf_pkg::OP_SETUP) && hd_setup_ok;
      ST_CMD_EX: begin
        we = can_go; waddr = cmd_ch; wdata = new_row;
      end
      ST_WALK_EX: begin
        we = can_go; waddr = ctr_q[CW-1:0]; wdata = new_row;
      end
      default: we = 1'b0;
    endcase
  end

  assign pop_o     = (state_q == ST_IDLE);
  assign m_valid_o = out_vld_q;
  assign m_res_o   = out_q;
  assign m_last_o  = out_last_q;
  assign m_fs_o    = out_fs_q;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) vld_q[waddr] <= 1'b1;
      if (re) rd_vld_q <= vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      ctr_q       <= '0;
      lim_q       <= '0;
      fs_walk_q   <= 1'b0;
      have_cmd_q  <= 1'b0;
      last_time_q <= '0;
      fs_q        <= 1'b0;
      pend_vld_q  <= 1'b0;
      pend_q      <= '0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
      out_last_q  <= 1'b0;
      out_fs_q    <= 1'b0;
    end else begin
      if (out_vld_q && m_ready_i && !out_load) out_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (head_i.valid) begin
            item_q <= hd;
            case (hd.op)
              aopf_pkg::OP_COMMAND: begin
                if (hd_cmd_ok) begin
                  have_cmd_q  <= 1'b1;
                  last_time_q <= hd.now_us;
                  state_q     <= ST_CMD_RD;
                end
              end
              aopf_pkg::OP_TICK: begin
                ctr_q <= '0;
                lim_q <= CNTW'(svc);
                if (!stale) begin
                  fs_q      <= 1'b0;
                  fs_walk_q <= 1'b0;
                  state_q   <= (svc == '0) ? ST_IDLE : ST_WALK_RD;
                end else if (!fs_q) begin
                  fs_q      <= 1'b1;
                  fs_walk_q <= 1'b1;
                  state_q   <= (svc == '0) ? ST_IDLE : ST_WALK_RD;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_CMD_RD: begin
          fs_walk_q <= 1'b0;
          state_q   <= ST_CMD_EX;
        end
        ST_WALK_RD: state_q <= ST_WALK_EX;
        ST_CMD_EX, ST_WALK_EX: begin
          if (can_go) begin
            if (emit) begin
              // pass the held result on, keep the new one until we know if it is last
              if (pend_vld_q) begin
                out_vld_q  <= 1'b1;
                out_q      <= pend_q;
                out_last_q <= 1'b0;
                out_fs_q   <= fs_q;
              end
              pend_vld_q   <= 1'b1;
              pend_q.ch    <= 5'(raddr_hold(state_q, cmd_ch, ctr_q[CW-1:0]));
              pend_q.width <= emit_w;
            end
            if (state_q == ST_CMD_EX) begin
              state_q <= ST_FLUSH;
            end else begin
              ctr_q   <= ctr_q + 1'b1;
              state_q <= ((ctr_q + 1'b1) == lim_q) ? ST_FLUSH : ST_WALK_RD;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_vld_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_vld_q  <= 1'b1;
            out_q      <= pend_q;
            out_last_q <= 1'b1;
            out_fs_q   <= fs_q;
            pend_vld_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/actuator_output_pulse_failsafe.sv =====
// Actuator output controller for up to CHANNELS channels (disabled, PWM, on/off or
// single-shot pulse). Items enter a two-word queue and run one at a time; a tick walks
// the serviced channels through the single-port channel table, and a stalled result
// output holds the item up. Each result word carries channel and width; tlast marks
// the last word of an item and tuser is the failsafe flag after that item.
// Configuration is always ready.
module actuator_output_pulse_failsafe #(
  parameter int CHANNELS = aopf_pkg::Channels
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_us, chan_id, cmd_value, command_is_pwm, setup_kind, setup_on_width,
  // setup_off_width, setup_safe_width, setup_safe_on, setup_pulse_ms, setup_restart
  input  logic [127:0] s_axis_tdata,
  // opcode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_channel, out_width
  output logic [23:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // failsafe_now
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  aopf_pkg::cfg_t   cfg_q;
  aopf_pkg::qhead_t head;
  aopf_pkg::res_t   res;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms   <= aopf_pkg::RstTimeoutMs;
      cfg_q.outputs      <= aopf_pkg::RstOutputs;
      cfg_q.pwm_floor    <= aopf_pkg::RstFloor;
      cfg_q.pwm_ceiling  <= aopf_pkg::RstCeiling;
      cfg_q.on_threshold <= aopf_pkg::RstThreshold;
    end else if (cfg_valid_i) begin
      case (aopf_pkg::cfg_reg_e'(cfg_index_i))
        aopf_pkg::REG_TIMEOUT:   cfg_q.timeout_ms   <= cfg_data_i;
        aopf_pkg::REG_OUTPUTS:   cfg_q.outputs      <= cfg_data_i[5:0];
        aopf_pkg::REG_FLOOR:     cfg_q.pwm_floor    <= cfg_data_i;
        aopf_pkg::REG_CEILING:   cfg_q.pwm_ceiling  <= cfg_data_i;
        aopf_pkg::REG_THRESHOLD: cfg_q.on_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aopf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .head_o        (head),
    .pop_i         (pop)
  );

  aopf_back #(.CHANNELS(CHANNELS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .head_i    (head),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res),
    .m_last_o  (m_axis_tlast),
    .m_fs_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, res.width, res.ch};

endmodule

// ===== rtl/aopf_checker.sv =====
module aopf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [127:0] s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [23:0]  m_axis_tdata,
  input logic         m_axis_tlast,
  input logic         m_axis_tuser,
  input logic         cfg_valid_i,
  input logic         cfg_ready_o,
  input logic [2:0]   cfg_index_i,
  input logic [15:0]  cfg_data_i
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // failsafe flag is the same on every word of one item
  a_fs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast
      |=> !m_axis_tvalid || (m_axis_tuser == $past(m_axis_tuser)))
    else $error("failsafe flag changed within one item");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:21] == 3'b000)
    else $error("result padding not zero");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind actuator_output_pulse_failsafe aopf_checker u_aopf_checker (.*);
